FILE: src/border_bounding_box_finder_top_assert.svh
// Assertion macros for the border bounding box finder.
`ifndef BORDER_BOUNDING_BOX_FINDER_TOP_ASSERT_SVH
`define BORDER_BOUNDING_BOX_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbf assertion failed");

// Next-cycle implication, checked outside reset.
`define BBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbf assertion failed");

`endif

FILE: src/bbf_pkg.sv
// Shared types and constants for the border bounding box finder.
`default_nettype none
package bbf_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int SIZE_W    = 13;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = Q_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic STATUS_BOX = 1'b0;
  localparam logic STATUS_BG  = 1'b1;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic               hit;
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } box_item_t;

  // Queue occupancy seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a raw size register to the index of the last column or row.
  function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] eff;
    if (v == '0) begin
      eff = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      eff = SIZE_W'(MAX_DIM);
    end else begin
      eff = v;
    end
    return COORD_W'(eff - SIZE_W'(1));
  endfunction

endpackage
`default_nettype wire

FILE: src/bbf_if.sv
// Handshake interfaces: pixel requests, result requests and register writes.
`default_nettype none
interface bbf_pix_if import bbf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bbf_res_if import bbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [SIZE_W-1:0]  crop_width;
  logic [SIZE_W-1:0]  crop_height;
  modport source (output valid, status, left, top, crop_width, crop_height, input ready);
  modport sink   (input valid, status, left, top, crop_width, crop_height, output ready);
endinterface

interface bbf_cfg_if import bbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [SIZE_W-1:0]    wdata;
  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface
`default_nettype wire

FILE: src/border_bounding_box_finder_top.sv
// Top level of the border bounding box finder (autocrop). Pixel requests (24-bit
// RGB, raster order) are taken at one per cycle while the queue has room. The
// frame size comes from two registers, image_width (index 0) and image_height
// (index 1); 0 reads as 1 and values above 4096 read as 4096. Write them only
// while no frame is in flight. The first pixel of a frame is the background;
// every other pixel that differs from it widens a box of least/greatest column
// and row. After the last pixel of a frame one result request leaves: status 0
// with left, top, crop_width and crop_height, or status 1 with zeros when the
// whole frame matched the background. Sustained rate is one pixel per cycle
// while results are taken, set by the single compare-and-update step in the
// back end. A result is registered behind the queue; a four-entry queue between
// the front (position tracking, background compare) and the back (box update,
// result register) keeps pixels flowing while a result waits to be taken.
`default_nettype none
module border_bounding_box_finder_top import bbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bbf_pix_if.sink   in_ch,
  bbf_cfg_if.sink   cfg_ch,
  bbf_res_if.source out_ch
);

`include "border_bounding_box_finder_top_assert.svh"

  logic      push, pop;
  box_item_t push_item, head_item;
  q_stat_t   qstat;

  // front: classifies each pixel against the latched background
  bbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // queue: decouples pixel intake from result backpressure
  bbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  // back: min/max box and output register
  bbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .qstat     (qstat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // a request is never pushed into a full queue
  `BBF_ASSERT_NOW(a_no_push_full, push, !qstat.full)
  // the back never pops an empty queue
  `BBF_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty)
  // a frame-end item always produces a pending result
  `BBF_ASSERT_NEXT(a_frame_end_result, pop && head_item.last, out_ch.valid)

endmodule
`default_nettype wire

FILE: src/bbf_queue.sv
// Short FIFO of classified pixels between front and back.
`default_nettype none
module bbf_queue import bbf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire box_item_t push_item,
  input  wire logic      pop,
  output box_item_t      head_item,
  output q_stat_t        stat
);

  box_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/bbf_front.sv
// Front end: size registers, raster position and background compare.
`default_nettype none
module bbf_front import bbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bbf_pix_if.sink   in_ch,
  bbf_cfg_if.sink   cfg_ch,
  input  wire q_stat_t qstat,
  output logic      push,
  output box_item_t push_item
);

  logic [COORD_W-1:0] col_last_r, col_last_nxt;
  logic [COORD_W-1:0] row_last_r, row_last_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0]   bg_r, bg_nxt;
  logic [PIX_W-1:0]   pixel;
  logic               first, row_end, frame_end;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !qstat.full;
  assign push         = in_ch.valid && in_ch.ready;

  assign pixel     = {in_ch.red, in_ch.green, in_ch.blue};
  assign first     = (col_r == '0) && (row_r == '0);
  assign row_end   = (col_r >= col_last_r);
  assign frame_end = row_end && (row_r >= row_last_r);

  assign push_item.hit  = !first && (pixel != bg_r);
  assign push_item.last = frame_end;
  assign push_item.col  = col_r;
  assign push_item.row  = row_r;

  // Registers hold the last index so the size clamp stays off the pixel path.
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.reg_idx))
        REG_IMAGE_WIDTH:  col_last_nxt = last_index(cfg_ch.wdata);
        REG_IMAGE_HEIGHT: row_last_nxt = last_index(cfg_ch.wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    bg_nxt  = bg_r;
    if (push) begin
      if (first) begin
        bg_nxt = pixel;
      end
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + COORD_W'(1);
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= '0;
      row_last_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      bg_r       <= '0;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      bg_r       <= bg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/bbf_back.sv
// Back end: running box update and result register.
`default_nettype none
module bbf_back import bbf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire box_item_t head_item,
  input  wire q_stat_t   qstat,
  output logic           pop,
  bbf_res_if.source      out_ch
);

  logic [COORD_W-1:0] min_c_r, min_c_nxt, max_c_r, max_c_nxt;
  logic [COORD_W-1:0] min_r_r, min_r_nxt, max_r_r, max_r_nxt;
  logic               found_r, found_nxt;
  logic [COORD_W-1:0] u_min_c, u_max_c, u_min_r, u_max_r;
  logic               u_found;
  logic               out_valid_r, out_valid_nxt;
  logic               status_r, status_nxt;
  logic [COORD_W-1:0] left_r, left_nxt, top_r, top_nxt;
  logic [SIZE_W-1:0]  cw_r, cw_nxt, ch_r, ch_nxt;
  logic               emit;

  // Only a frame-end item needs the result register free.
  assign pop  = !qstat.empty && (!head_item.last || !out_valid_r || out_ch.ready);
  assign emit = pop && head_item.last;

  always_comb begin
    u_min_c = min_c_r;
    u_max_c = max_c_r;
    u_min_r = min_r_r;
    u_max_r = max_r_r;
    u_found = found_r;
    if (head_item.hit) begin
      if (head_item.col < min_c_r) u_min_c = head_item.col;
      if (head_item.col > max_c_r) u_max_c = head_item.col;
      if (head_item.row < min_r_r) u_min_r = head_item.row;
      if (head_item.row > max_r_r) u_max_r = head_item.row;
      u_found = 1'b1;
    end
  end

  always_comb begin
    min_c_nxt = min_c_r;
    max_c_nxt = max_c_r;
    min_r_nxt = min_r_r;
    max_r_nxt = max_r_r;
    found_nxt = found_r;
    if (pop) begin
      if (head_item.last) begin
        min_c_nxt = '1;
        max_c_nxt = '0;
        min_r_nxt = '1;
        max_r_nxt = '0;
        found_nxt = 1'b0;
      end else begin
        min_c_nxt = u_min_c;
        max_c_nxt = u_max_c;
        min_r_nxt = u_min_r;
        max_r_nxt = u_max_r;
        found_nxt = u_found;
      end
    end
  end

  always_comb begin
    status_nxt = status_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    cw_nxt     = cw_r;
    ch_nxt     = ch_r;
    if (emit) begin
      if (u_found) begin
        status_nxt = STATUS_BOX;
        left_nxt   = u_min_c;
        top_nxt    = u_min_r;
        cw_nxt     = {1'b0, u_max_c} - {1'b0, u_min_c} + SIZE_W'(1);
        ch_nxt     = {1'b0, u_max_r} - {1'b0, u_min_r} + SIZE_W'(1);
      end else begin
        status_nxt = STATUS_BG;
        left_nxt   = '0;
        top_nxt    = '0;
        cw_nxt     = '0;
        ch_nxt     = '0;
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_c_r     <= '1;
      max_c_r     <= '0;
      min_r_r     <= '1;
      max_r_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      min_c_r     <= min_c_nxt;
      max_c_r     <= max_c_nxt;
      min_r_r     <= min_r_nxt;
      max_r_r     <= max_r_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    left_r   <= left_nxt;
    top_r    <= top_nxt;
    cw_r     <= cw_nxt;
    ch_r     <= ch_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.left        = left_r;
  assign out_ch.top         = top_r;
  assign out_ch.crop_width  = cw_r;
  assign out_ch.crop_height = ch_r;

endmodule
`default_nettype wire

FILE: dv/border_bounding_box_finder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the autocrop bounding box finder: scripted frames, then random ones.
module border_bounding_box_finder_top_tb;
  import bbf_pkg::*;

  // Quiet cycles (no request on any channel) before the run is declared hung.
  // The longest legal quiet stretch is the forced result hold below plus the drain
  // through the queue and result register, so this is several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  // A result passes the queue between front and back and then the result register
  // after its last pixel. Pad generously.
  localparam int DRAIN_CYCLES   = 8;
  localparam int END_CYCLES     = 20;
  // Random pixels in ordinary small frames, on top of the scripted part.
  localparam int RANDOM_PIXELS  = 820;
  localparam int CALM_PIXELS    = 150;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic               status;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  crop_width;
    logic [SIZE_W-1:0]  crop_height;
  } crop_t;

  localparam crop_t ALL_BG = '{STATUS_BG, '0, '0, '0, '0};

  typedef enum bit {STEP_CFG, STEP_PIX} step_kind_t;

  // One row of the scripted part: either a size write or a pixel. A pixel row
  // may carry a hand-typed crop that replaces the predicted one.
  typedef struct {
    step_kind_t        kind;
    cfg_reg_t          idx;
    logic [SIZE_W-1:0] value;
    logic [PIX_W-1:0]  rgb;
    bit                typed;
    crop_t             want;
  } script_step_t;

  logic clk;
  logic rst_n;

  bbf_pix_if pix_if ();
  bbf_res_if res_if ();
  bbf_cfg_if cfg_if ();

  border_bounding_box_finder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_if),
    .cfg_ch (cfg_if),
    .out_ch (res_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow size registers plus the running box of the frame.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [PIX_W-1:0]  bg_rgb;
  int unsigned       cur_col;
  int unsigned       cur_row;
  int unsigned       min_col;
  int unsigned       max_col;
  int unsigned       min_row;
  int unsigned       max_row;
  bit                box_seen;

  crop_t pending_crops[$];   // crops predicted, oldest first

  bit idle_on;    // random gaps on both sides
  bit hold_req;   // asks the result side for one long hold-off

  int mismatches;
  int results_seen;
  int bg_results;
  int pixels_sent;
  int size_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Out-of-range sizes: 0 behaves as 1, anything past MAX_DIM as MAX_DIM.
  function automatic int unsigned eff_dim(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  task automatic restart_frame();
    cur_col  = 0;
    cur_row  = 0;
    min_col  = MAX_DIM - 1;
    max_col  = 0;
    min_row  = MAX_DIM - 1;
    max_row  = 0;
    box_seen = 1'b0;
  endtask

  // Advance the frame by one accepted pixel; done is set on the last pixel.
  task automatic track_pixel(input logic [PIX_W-1:0] rgb, output bit done, output crop_t box);
    int unsigned w;
    int unsigned h;
    bit          row_end;
    bit          frame_end;
    w         = eff_dim(width_reg);
    h         = eff_dim(height_reg);
    // Position is compared with >= so a size shrunk under a running frame
    // still closes the row or frame.
    row_end   = cur_col >= w - 1;
    frame_end = row_end && cur_row >= h - 1;
    done      = 1'b0;
    box       = ALL_BG;
    if (cur_col == 0 && cur_row == 0) begin
      bg_rgb = rgb;   // first pixel of the frame is the background
    end else if (rgb != bg_rgb) begin
      if (cur_col < min_col) min_col = cur_col;
      if (cur_col > max_col) max_col = cur_col;
      if (cur_row < min_row) min_row = cur_row;
      if (cur_row > max_row) max_row = cur_row;
      box_seen = 1'b1;
    end
    if (frame_end) begin
      done = 1'b1;
      if (box_seen) begin
        box = '{STATUS_BOX, COORD_W'(min_col), COORD_W'(min_row),
                SIZE_W'(max_col - min_col + 1), SIZE_W'(max_row - min_row + 1)};
      end
      restart_frame();
    end else if (row_end) begin
      cur_col = 0;
      cur_row = cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side. Every task here starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_W-1:0] rgb, input bit typed, input crop_t want);
    int    gap;
    bit    done;
    crop_t box;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= rgb[23:16];
    pix_if.green <= rgb[15:8];
    pix_if.blue  <= rgb[7:0];
    do @(posedge clk); while (!pix_if.ready);
    track_pixel(rgb, done, box);
    if (typed) begin
      pending_crops.push_back(want);
    end else if (done) begin
      pending_crops.push_back(box);
    end
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stop offering pixels until every predicted crop has been taken, then let
  // the pipeline settle.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (pending_crops.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Size writes only happen on an empty block: drain first, every time.
  task automatic write_size(input cfg_reg_t idx, input logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One whole frame with a random background; density is the percentage of
  // pixels that differ from it.
  task automatic send_frame(input int density);
    int unsigned      area;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] rgb;
    area = eff_dim(width_reg) * eff_dim(height_reg);
    bg   = PIX_W'($urandom());
    for (int unsigned i = 0; i < area; i++) begin
      rgb = bg;
      if (i != 0 && $urandom_range(0, 99) < density) begin
        case ($urandom_range(0, 2))
          0: rgb = bg ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));   // one bit off
          1: rgb = PIX_W'($urandom());
          default: rgb = ~bg;
        endcase
      end
      // now and then the sender sits out mid-frame until all crops are back
      if (i == area / 2 && area > 1 && $urandom_range(0, 7) == 0) wait_drained();
      send_pixel(rgb, 1'b0, ALL_BG);
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'($urandom_range(9, 24));
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 3;
      2: return 15;
      3: return 50;
      default: return 100;
    endcase
  endfunction

  function automatic script_step_t cfg_step(cfg_reg_t idx, logic [SIZE_W-1:0] value);
    script_step_t s;
    s       = '{STEP_CFG, idx, value, '0, 1'b0, ALL_BG};
    return s;
  endfunction

  function automatic script_step_t pix_step(logic [PIX_W-1:0] rgb);
    script_step_t s;
    s       = '{STEP_PIX, REG_IMAGE_WIDTH, '0, rgb, 1'b0, ALL_BG};
    return s;
  endfunction

  function automatic script_step_t end_step(logic [PIX_W-1:0] rgb, crop_t want);
    script_step_t s;
    s       = '{STEP_PIX, REG_IMAGE_WIDTH, '0, rgb, 1'b1, want};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold on request, counted
  // here so the pixel side keeps pushing meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);   // start a stall burst
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare every taken result with the oldest predicted crop.
  initial begin : crop_checker
    crop_t got;
    crop_t want;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got = '{res_if.status, res_if.left, res_if.top, res_if.crop_width, res_if.crop_height};
        results_seen++;
        if (got.status == STATUS_BG) bg_results++;
        if (pending_crops.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected crop: status %0d left %0d top %0d w %0d h %0d",
                     got.status, got.left, got.top, got.crop_width, got.crop_height);
        end else begin
          want = pending_crops.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("crop %0d: want st %0d l %0d t %0d w %0d h %0d, got st %0d l %0d t %0d w %0d h %0d",
                       results_seen, want.status, want.left, want.top, want.crop_width,
                       want.crop_height, got.status, got.left, got.top, got.crop_width,
                       got.crop_height);
          end
        end
      end
    end
  end

  // Hang detection: cycles in which no channel moves a request.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d quiet cycles, %0d crops outstanding", quiet, pending_crops.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_step_t script[$];
    int           frames;
    int           small_pixels;
    int           mark;
    int unsigned  area;

    rst_n          = 1'b0;
    pix_if.valid   = 1'b0;
    pix_if.red     = '0;
    pix_if.green   = '0;
    pix_if.blue    = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.reg_idx = REG_IMAGE_WIDTH;
    cfg_if.wdata   = '0;
    hold_req       = 1'b0;
    idle_on        = 1'b1;
    mismatches     = 0;
    results_seen   = 0;
    bg_results     = 0;
    pixels_sent    = 0;
    size_settings  = 0;
    small_pixels   = 0;
    width_reg      = SIZE_W'(1);
    height_reg     = SIZE_W'(1);
    bg_rgb         = '0;
    restart_frame();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Scripted frames. Sizes reset to 1x1, so each lone pixel is a full frame
    // whose only pixel is the background.
    script.push_back(end_step(24'h000000, ALL_BG));
    script.push_back(end_step(24'hFFFFFF, ALL_BG));
    // zero sizes read as 1
    script.push_back(cfg_step(REG_IMAGE_WIDTH, '0));
    script.push_back(cfg_step(REG_IMAGE_HEIGHT, '0));
    script.push_back(end_step(24'h123456, ALL_BG));
    // 2x2: each channel differs once, box covers the frame
    script.push_back(cfg_step(REG_IMAGE_WIDTH, SIZE_W'(2)));
    script.push_back(cfg_step(REG_IMAGE_HEIGHT, SIZE_W'(2)));
    script.push_back(pix_step(24'h0A141E));
    script.push_back(pix_step(24'h0A141F));
    script.push_back(pix_step(24'h0A151E));
    script.push_back(end_step(24'h0B141E, '{STATUS_BOX, 12'd0, 12'd0, 13'd2, 13'd2}));
    // 2x2 all background
    script.push_back(pix_step(24'hFFFFFF));
    script.push_back(pix_step(24'hFFFFFF));
    script.push_back(pix_step(24'hFFFFFF));
    script.push_back(end_step(24'hFFFFFF, ALL_BG));
    // single row, hit on the last column
    script.push_back(cfg_step(REG_IMAGE_WIDTH, SIZE_W'(3)));
    script.push_back(cfg_step(REG_IMAGE_HEIGHT, SIZE_W'(1)));
    script.push_back(pix_step(24'h000000));
    script.push_back(pix_step(24'h000000));
    script.push_back(end_step(24'h800000, '{STATUS_BOX, 12'd2, 12'd0, 13'd1, 13'd1}));
    // single column, hit in the middle row
    script.push_back(cfg_step(REG_IMAGE_WIDTH, SIZE_W'(1)));
    script.push_back(cfg_step(REG_IMAGE_HEIGHT, SIZE_W'(3)));
    script.push_back(pix_step(24'h00FF00));
    script.push_back(pix_step(24'h01FF00));
    script.push_back(end_step(24'h00FF00, '{STATUS_BOX, 12'd0, 12'd1, 13'd1, 13'd1}));
    // 2x3, checked by the predictor
    script.push_back(cfg_step(REG_IMAGE_WIDTH, SIZE_W'(2)));
    script.push_back(cfg_step(REG_IMAGE_HEIGHT, SIZE_W'(3)));
    script.push_back(pix_step(24'h555555));
    script.push_back(pix_step(24'hAAAAAA));
    script.push_back(pix_step(24'h555555));
    script.push_back(pix_step(24'h555555));
    script.push_back(pix_step(24'h55555A));
    script.push_back(pix_step(24'h555555));

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG) begin
        write_size(script[i].idx, script[i].value);
      end else begin
        send_pixel(script[i].rgb, script[i].typed, script[i].want);
      end
    end

    // Backpressure: 1x1 frames give a crop per pixel while the result side is
    // held off, so the internal queue fills and pixel ready must drop.
    write_size(REG_IMAGE_WIDTH, SIZE_W'(1));
    write_size(REG_IMAGE_HEIGHT, SIZE_W'(1));
    hold_req = 1'b1;
    repeat (40) send_pixel(PIX_W'($urandom()), 1'b0, ALL_BG);

    // Random phases: a new size pair each time, a few frames per size, trimmed
    // so the run stays close to its pixel budget.
    while (small_pixels < RANDOM_PIXELS) begin
      idle_on = small_pixels < RANDOM_PIXELS - CALM_PIXELS;
      write_size(REG_IMAGE_WIDTH, pick_size());
      write_size(REG_IMAGE_HEIGHT, pick_size());
      frames = $urandom_range(1, 6);
      area   = eff_dim(width_reg) * eff_dim(height_reg);
      while (frames > 1 && frames * area > RANDOM_PIXELS - small_pixels) frames--;
      size_settings++;
      mark = pixels_sent;
      repeat (frames) send_frame(pick_density());
      small_pixels += pixels_sent - mark;
    end

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);

    $display("Sent %0d pixels over %0d random size settings plus scripted frames.",
             pixels_sent, size_settings);
    $display("Checked %0d crops (%0d all background), %0d mismatches, %0d outstanding.",
             results_seen, bg_results, mismatches, pending_crops.size());
    if (mismatches == 0 && pending_crops.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bbf_pkg.sv
src/bbf_if.sv
src/bbf_queue.sv
src/bbf_front.sv
src/bbf_back.sv
src/border_bounding_box_finder_top.sv
dv/border_bounding_box_finder_top_tb.sv
